// ----- hw/rtl/sra_pkg.sv -----
package sra_pkg;

  // Ring depths
  localparam int FREQ_DEPTH = 4;
  localparam int TEMP_DEPTH = 8;

  // Field widths
  localparam int FREQ_W     = 16;
  localparam int TEMP_W     = 12;
  localparam int COOL_AVG_W = 13;

  // Pointer and walk counter widths
  localparam int FPTR_W   = $clog2(FREQ_DEPTH);
  localparam int TPTR_W   = $clog2(TEMP_DEPTH);
  localparam int WALK_LEN = (FREQ_DEPTH > TEMP_DEPTH) ? FREQ_DEPTH : TEMP_DEPTH;
  localparam int CNT_W    = $clog2(WALK_LEN + 1);

  // Accumulator widths
  localparam int CLAMP_W = COOL_AVG_W + 1;
  localparam int CSUM_W  = CLAMP_W + $clog2(TEMP_DEPTH);
  localparam int TSUM_W  = TEMP_W + $clog2(TEMP_DEPTH);
  localparam int FSUM_W  = FREQ_W + $clog2(FREQ_DEPTH);

  // Request codes
  localparam logic FUNC_STORE   = 1'b0;
  localparam logic FUNC_AVERAGE = 1'b1;

  typedef struct packed {
    logic              func;
    logic [FREQ_W-1:0] freq_sample;
    logic [TEMP_W-1:0] coolant_sample;
    logic [TEMP_W-1:0] chip_temp_sample;
    logic              freq_only;
  } sra_in_t;

  typedef struct packed {
    logic [COOL_AVG_W-1:0] coolant_avg;
    logic [TEMP_W-1:0]     chip_temp_avg;
    logic [FREQ_W-1:0]     freq_avg;
  } sra_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } sra_state_e;

  // Controller to datapath
  typedef struct packed {
    logic store;   // write samples at the ring pointers
    logic start;   // clear accumulators and walk counter
    logic step;    // add one ring entry
    logic finish;  // load result and stored coolant average
  } sra_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_step;
  } sra_status_t;

endpackage

// ----- hw/rtl/sensor_ring_average_with_clamp.sv -----
// Sensor ring averager. A store request (func = 0) writes the frequency sample and, unless
// freq_only is set, the coolant and chip temperature samples into their rings at pointers
// that count down and wrap; it gives no result. An average request (func = 1) walks the
// rings one entry per cycle with a single set of accumulators, and new requests stall until
// it is done: it is accepted in idle, the walk state adds one entry per step over the longer
// ring depth, and the finish state forms the means and loads the result register. Coolant
// entries are clamped to the previous coolant average +/- 1/16 of it once that average is
// nonzero. The result register frees the input side: requests are taken while a result
// waits, and the finish step holds only if the previous result has not been taken yet.
module sensor_ring_average_with_clamp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sra_pkg::sra_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sra_pkg::sra_out_t out_data_o
);

  sra_pkg::sra_cmd_t    cmd;
  sra_pkg::sra_status_t status;

  sra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_func_i   (in_data_i.func),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sra_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

// ----- hw/rtl/sra_ctrl.sv -----
module sra_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_func_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  sra_pkg::sra_status_t status_i,
  output sra_pkg::sra_cmd_t   cmd_o
);

  sra_pkg::sra_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic in_acc;
  logic out_free;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sra_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != sra_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  // output register can take a new result this cycle
  assign out_free    = !out_valid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    out_valid_d  = out_valid_q && out_stall_i;
    unique case (state_q)
      sra_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_func_i == sra_pkg::FUNC_AVERAGE) begin
            cmd_o.start = 1'b1;
            state_d     = sra_pkg::ST_WALK;
          end else begin
            cmd_o.store = 1'b1;
          end
        end
      end
      sra_pkg::ST_WALK: begin
        cmd_o.step = 1'b1;
        if (status_i.last_step) begin
          state_d = sra_pkg::ST_FINISH;
        end
      end
      sra_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = sra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sra_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/sra_dp.sv -----
module sra_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sra_pkg::sra_cmd_t  cmd_i,
  input  sra_pkg::sra_in_t   in_data_i,
  output sra_pkg::sra_status_t status_o,
  output sra_pkg::sra_out_t  out_data_o
);

  logic [sra_pkg::FREQ_W-1:0] freq_ring_q    [sra_pkg::FREQ_DEPTH];
  logic [sra_pkg::TEMP_W-1:0] coolant_ring_q [sra_pkg::TEMP_DEPTH];
  logic [sra_pkg::TEMP_W-1:0] chip_ring_q    [sra_pkg::TEMP_DEPTH];
  logic [sra_pkg::FPTR_W-1:0] freq_ptr_q;
  logic [sra_pkg::TPTR_W-1:0] temp_ptr_q;
  logic [sra_pkg::COOL_AVG_W-1:0] cool_avg_q;

  logic [sra_pkg::CNT_W-1:0]  cnt_q;
  logic [sra_pkg::CSUM_W-1:0] csum_q;
  logic [sra_pkg::TSUM_W-1:0] tsum_q;
  logic [sra_pkg::FSUM_W-1:0] fsum_q;
  sra_pkg::sra_out_t          out_q;

  logic [sra_pkg::COOL_AVG_W-1:0] tol;
  logic [sra_pkg::CLAMP_W-1:0]    hi_lim;
  logic [sra_pkg::CLAMP_W-1:0]    lo_lim;
  logic [sra_pkg::CLAMP_W-1:0]    cool_raw;
  logic [sra_pkg::CLAMP_W-1:0]    cool_val;
  logic                           clamp_en;
  logic                           freq_act;
  logic                           temp_act;
  logic [sra_pkg::CSUM_W-1:0]     c_quot;
  logic [sra_pkg::TSUM_W-1:0]     t_quot;
  logic [sra_pkg::FSUM_W-1:0]     f_quot;

  // Coolant clamp window around the stored average
  assign clamp_en = (cool_avg_q != '0);
  assign tol      = cool_avg_q >> 4;
  assign hi_lim   = sra_pkg::CLAMP_W'(cool_avg_q) + sra_pkg::CLAMP_W'(tol);
  assign lo_lim   = sra_pkg::CLAMP_W'(cool_avg_q - tol);
  assign cool_raw = sra_pkg::CLAMP_W'(coolant_ring_q[cnt_q[sra_pkg::TPTR_W-1:0]]);

  always_comb begin
    cool_val = cool_raw;
    if (clamp_en && (cool_raw > hi_lim)) begin
      cool_val = hi_lim;
    end else if (clamp_en && (cool_raw < lo_lim)) begin
      cool_val = lo_lim;
    end
  end

  // Walk position inside each ring
  assign freq_act = (cnt_q < sra_pkg::CNT_W'(sra_pkg::FREQ_DEPTH));
  assign temp_act = (cnt_q < sra_pkg::CNT_W'(sra_pkg::TEMP_DEPTH));
  assign status_o.last_step = (cnt_q == sra_pkg::CNT_W'(sra_pkg::WALK_LEN - 1));

  // Means of the finished sums
  assign c_quot = sra_pkg::CSUM_W'(csum_q / sra_pkg::TEMP_DEPTH);
  assign t_quot = sra_pkg::TSUM_W'(tsum_q / sra_pkg::TEMP_DEPTH);
  assign f_quot = sra_pkg::FSUM_W'(fsum_q / sra_pkg::FREQ_DEPTH);

  // Rings, pointers and stored coolant average
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sra_pkg::FREQ_DEPTH; i++) begin
        freq_ring_q[i] <= '0;
      end
      for (int i = 0; i < sra_pkg::TEMP_DEPTH; i++) begin
        coolant_ring_q[i] <= '0;
        chip_ring_q[i]    <= '0;
      end
      freq_ptr_q <= sra_pkg::FPTR_W'(sra_pkg::FREQ_DEPTH - 1);
      temp_ptr_q <= sra_pkg::TPTR_W'(sra_pkg::TEMP_DEPTH - 1);
      cool_avg_q <= '0;
    end else begin
      if (cmd_i.store) begin
        freq_ring_q[freq_ptr_q] <= in_data_i.freq_sample;
        freq_ptr_q <= (freq_ptr_q == '0) ? sra_pkg::FPTR_W'(sra_pkg::FREQ_DEPTH - 1)
                                         : freq_ptr_q - 1'b1;
        if (!in_data_i.freq_only) begin
          coolant_ring_q[temp_ptr_q] <= in_data_i.coolant_sample;
          chip_ring_q[temp_ptr_q]    <= in_data_i.chip_temp_sample;
          temp_ptr_q <= (temp_ptr_q == '0) ? sra_pkg::TPTR_W'(sra_pkg::TEMP_DEPTH - 1)
                                           : temp_ptr_q - 1'b1;
        end
      end
      if (cmd_i.finish) begin
        cool_avg_q <= c_quot[sra_pkg::COOL_AVG_W-1:0];
      end
    end
  end

  // Walk counter and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      csum_q <= '0;
      tsum_q <= '0;
      fsum_q <= '0;
    end else if (cmd_i.step) begin
      if (temp_act) begin
        csum_q <= csum_q + sra_pkg::CSUM_W'(cool_val);
        tsum_q <= tsum_q + sra_pkg::TSUM_W'(chip_ring_q[cnt_q[sra_pkg::TPTR_W-1:0]]);
      end
      if (freq_act) begin
        fsum_q <= fsum_q + sra_pkg::FSUM_W'(freq_ring_q[cnt_q[sra_pkg::FPTR_W-1:0]]);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.coolant_avg   <= c_quot[sra_pkg::COOL_AVG_W-1:0];
      out_q.chip_temp_avg <= t_quot[sra_pkg::TEMP_W-1:0];
      out_q.freq_avg      <= f_quot[sra_pkg::FREQ_W-1:0];
    end
  end

  assign out_data_o = out_q;

endmodule
